/* rtl/smp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smp_pkg
// Shared types and constants of the sequence pattern matcher.
// ----------------------------------------------------------------------------
package smp_pkg;

  // Fixed widths of the channel payloads
  localparam int WORD_W    = 32;
  localparam int POS_OUT_W = 16;

  // Function codes of an input transaction
  localparam logic FUNC_PATTERN = 1'b0;
  localparam logic FUNC_TEXT    = 1'b1;

  // Control handed to every cell of the chain
  typedef struct packed {
    logic shift;  // a text word is accepted: advance the match bits
    logic clear;  // drop all match bits
  } cell_ctl_t;

  // One result transaction
  typedef struct packed {
    logic                 found;
    logic [POS_OUT_W-1:0] first_position;
    logic [POS_OUT_W-1:0] last_position;
  } res_t;

endpackage

/* rtl/smp_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smp_in_if
// Input channel: pattern and text words with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface smp_in_if import smp_pkg::*; ();

  logic                     valid;
  logic                     ready;
  logic                     func;
  logic signed [WORD_W-1:0] word;
  logic                     last;

  modport source (output valid, output func, output word, output last, input ready);
  modport sink   (input valid, input func, input word, input last, output ready);

endinterface

/* rtl/smp_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smp_out_if
// Result channel: search outcome with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface smp_out_if import smp_pkg::*; ();

  logic                 valid;
  logic                 ready;
  logic                 found;
  logic [POS_OUT_W-1:0] first_position;
  logic [POS_OUT_W-1:0] last_position;

  modport source (output valid, output found, output first_position,
                  output last_position, input ready);
  modport sink   (input valid, input found, input first_position,
                  input last_position, output ready);

endinterface

/* rtl/sequence_pattern_matcher_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequence_pattern_matcher_core
// Streaming search of a stored pattern in a text, reporting the first and
// the last start position of the pattern.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries one word per transaction. func = 0 loads a pattern word
//          (last = 1 closes the pattern), func = 1 streams a text word
//          (last = 1 closes the text). A new pattern replaces the old one
//          and drops any partial text search; words beyond MAX_PATTERN
//          are dropped.
//   out_ch carries one result per text, produced by its last word: found
//          and the 1-based first and last start positions (0 if none).
//          An empty pattern reports found with both positions 0.
// Throughput: one input transaction per cycle while in_ch.ready is high;
//   each pattern word sits in a cell of a chain; every text word is compared
//   in all cells at once and the match bits move one cell along per word.
// Output: each result is registered in smp_out_q before out_ch shows it.
// Stall: a result waiting on out_ch.ready stays in the output register
//   while input continues; one more result parks in a skid slot, and only
//   then in_ch.ready drops until the receiver takes one.
// Reset: clears the pattern length, match bits and position counter; the
//   stored pattern words are not cleared.
// ----------------------------------------------------------------------------
module sequence_pattern_matcher_core import smp_pkg::*; #(
  parameter int MAX_PATTERN   = 16,
  parameter int POSITION_BITS = 16,
  parameter int WORD_BITS     = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  smp_in_if.sink    in_ch,
  smp_out_if.source out_ch
);

  localparam int CMP_W = (WORD_BITS < WORD_W) ? WORD_BITS : WORD_W;
  localparam int CNT_W = $clog2(MAX_PATTERN + 1);
  localparam int POS_W = POSITION_BITS;

  // Pattern bookkeeping
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             complete_r, complete_nxt;
  logic [CNT_W-1:0] wr_idx;

  // Text bookkeeping
  logic [POS_W-1:0] pos_r, pos_nxt, pos_new;
  logic             seen_r, seen_nxt, seen_new;
  logic [POS_W-1:0] first_r, first_nxt, first_new;
  logic [POS_W-1:0] last_r, last_nxt, last_new;
  logic [POS_W-1:0] start;

  logic             accept;
  logic             load;
  logic             text;
  logic             push_ready;
  logic             top_hit;
  cell_ctl_t        ctl;
  res_t             push_data;
  logic [CMP_W-1:0] word_cmp;

  logic [MAX_PATTERN-1:0] wr_en;
  logic [MAX_PATTERN-1:0] active;
  logic [MAX_PATTERN-1:0] hit;
  logic [MAX_PATTERN:0]   chain;

  assign in_ch.ready = push_ready;
  assign accept      = in_ch.valid & in_ch.ready;
  assign load        = accept & (in_ch.func == FUNC_PATTERN);
  assign text        = accept & (in_ch.func == FUNC_TEXT);
  assign word_cmp    = in_ch.word[CMP_W-1:0];

  // Any pattern word, and the end of a text, drop the alignment state
  assign ctl.shift = text;
  assign ctl.clear = load | (text & in_ch.last);

  // A pattern word after a closed pattern starts again at cell 0
  assign wr_idx = complete_r ? '0 : count_r;

  // ---------------------------------------------------------------------
  // Chain of alignment cells; cell 0 always opens a new alignment
  // ---------------------------------------------------------------------
  assign chain[0] = 1'b1;

  for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
    assign wr_en[g]  = load & (wr_idx == CNT_W'(g));
    assign active[g] = (count_r > CNT_W'(g));

    smp_cell #(
      .CMP_W (CMP_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .wr_en     (wr_en[g]),
      .active    (active[g]),
      .word      (word_cmp),
      .match_in  (chain[g]),
      .match_out (chain[g+1]),
      .hit       (hit[g])
    );
  end

  // Full match: the bit of the cell holding the final pattern word
  always_comb begin
    top_hit = 1'b0;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      top_hit = top_hit | (hit[k] & (count_r == CNT_W'(k + 1)));
    end
  end

  // ---------------------------------------------------------------------
  // Position tracking; the counter saturates at its top value
  // ---------------------------------------------------------------------
  assign pos_new = (pos_r == {POS_W{1'b1}}) ? pos_r : pos_r + POS_W'(1);
  assign start   = (pos_new >= POS_W'(count_r)) ?
                   pos_new - POS_W'(count_r) + POS_W'(1) : '0;

  always_comb begin
    seen_new  = seen_r;
    first_new = first_r;
    last_new  = last_r;
    if (top_hit) begin
      if (!seen_r) begin
        first_new = start;
      end
      last_new = start;
      seen_new = 1'b1;
    end
  end

  // ---------------------------------------------------------------------
  // State update
  // ---------------------------------------------------------------------
  always_comb begin
    count_nxt    = count_r;
    complete_nxt = complete_r;
    pos_nxt      = pos_r;
    seen_nxt     = seen_r;
    first_nxt    = first_r;
    last_nxt     = last_r;
    if (load) begin
      count_nxt    = (wr_idx < CNT_W'(MAX_PATTERN)) ? wr_idx + CNT_W'(1) : wr_idx;
      complete_nxt = in_ch.last;
      pos_nxt      = '0;
      seen_nxt     = 1'b0;
      first_nxt    = '0;
      last_nxt     = '0;
    end else if (text) begin
      complete_nxt = 1'b1;
      if (in_ch.last) begin
        pos_nxt   = '0;
        seen_nxt  = 1'b0;
        first_nxt = '0;
        last_nxt  = '0;
      end else begin
        pos_nxt   = pos_new;
        seen_nxt  = seen_new;
        first_nxt = first_new;
        last_nxt  = last_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      complete_r <= 1'b1;
      pos_r      <= '0;
      seen_r     <= 1'b0;
      first_r    <= '0;
      last_r     <= '0;
    end else begin
      count_r    <= count_nxt;
      complete_r <= complete_nxt;
      pos_r      <= pos_nxt;
      seen_r     <= seen_nxt;
      first_r    <= first_nxt;
      last_r     <= last_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Result on the last text word; an empty pattern always reports found
  // ---------------------------------------------------------------------
  assign push_data.found          = (count_r == '0) | seen_new;
  assign push_data.first_position = POS_OUT_W'(first_new);
  assign push_data.last_position  = POS_OUT_W'(last_new);

  smp_out_q u_out_q (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (text & in_ch.last),
    .push_data  (push_data),
    .push_ready (push_ready),
    .out_ch     (out_ch)
  );

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_PATTERN))
    else $error("pattern length beyond cell count");

  a_first_not_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r |-> (first_r <= last_r))
    else $error("first start after last start");

  a_no_pos_without_match: assert property (@(posedge clk) disable iff (!rst_n)
    !seen_r |-> (first_r == '0 && last_r == '0))
    else $error("start position recorded without a match");

endmodule

/* rtl/smp_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smp_cell
// One alignment cell: holds one pattern word and the match bit of its
// alignment, and passes the bit on to the next cell.
// ----------------------------------------------------------------------------
module smp_cell import smp_pkg::*; #(
  parameter int CMP_W = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cell_ctl_t        ctl,
  input  logic             wr_en,
  input  logic             active,
  input  logic [CMP_W-1:0] word,
  input  logic             match_in,
  output logic             match_out,
  output logic             hit
);

  logic [CMP_W-1:0] pat_r;
  logic             match_r;
  logic             match_nxt;

  // New match bit of this alignment for the word on the bus
  assign hit = match_in & active & (pat_r == word);

  always_comb begin
    match_nxt = match_r;
    if (ctl.clear) begin
      match_nxt = 1'b0;
    end else if (ctl.shift) begin
      match_nxt = hit;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pat_r <= word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else begin
      match_r <= match_nxt;
    end
  end

  assign match_out = match_r;

endmodule

/* rtl/smp_out_q.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smp_out_q
// Two-entry result buffer: output register plus one skid slot.
// ----------------------------------------------------------------------------
module smp_out_q import smp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  res_t      push_data,
  output logic      push_ready,
  smp_out_if.source out_ch
);

  logic head_v_r, head_v_nxt;
  logic spare_v_r, spare_v_nxt;
  res_t head_r, head_nxt;
  res_t spare_r, spare_nxt;
  logic pop;

  assign pop        = head_v_r & out_ch.ready;
  assign push_ready = ~spare_v_r;

  always_comb begin
    head_v_nxt  = head_v_r;
    head_nxt    = head_r;
    spare_v_nxt = spare_v_r;
    spare_nxt   = spare_r;
    if (!head_v_r || pop) begin
      if (spare_v_r) begin
        // advance the skid slot, refill it from the new result
        head_nxt    = spare_r;
        head_v_nxt  = 1'b1;
        spare_v_nxt = push;
        spare_nxt   = push_data;
      end else begin
        head_nxt   = push_data;
        head_v_nxt = push;
      end
    end else if (push) begin
      // hold the head, park the new result
      spare_v_nxt = 1'b1;
      spare_nxt   = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_v_r  <= 1'b0;
      spare_v_r <= 1'b0;
    end else begin
      head_v_r  <= head_v_nxt;
      spare_v_r <= spare_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r  <= head_nxt;
    spare_r <= spare_nxt;
  end

  assign out_ch.valid          = head_v_r;
  assign out_ch.found          = head_r.found;
  assign out_ch.first_position = head_r.first_position;
  assign out_ch.last_position  = head_r.last_position;

  a_spare_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
    spare_v_r |-> head_v_r)
    else $error("skid slot full while output register empty");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    spare_v_r |-> !push)
    else $error("result pushed into full buffer");

  a_head_held: assert property (@(posedge clk) disable iff (!rst_n)
    (head_v_r && !out_ch.ready) |=> (head_v_r && $stable(head_r)))
    else $error("stalled result changed before it was taken");

endmodule

/* verif/sequence_pattern_matcher_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequence_pattern_matcher_checker
// Watches both channels of the pattern matcher, predicts each search result
// from the accepted words and compares every returned result field by field.
// ----------------------------------------------------------------------------
module sequence_pattern_matcher_checker import smp_pkg::*; #(
  parameter int MAX_PATTERN   = 16,
  parameter int POSITION_BITS = 16,
  parameter int WORD_BITS     = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  smp_in_if           in_ch,
  smp_out_if          out_ch,
  output int unsigned failures,
  output int unsigned outstanding,
  output int unsigned results_checked,
  output int unsigned pattern_words,
  output int unsigned text_words
);

  localparam int unsigned PRINT_CAP = 60;

  // Predicted search state
  logic [WORD_BITS-1:0]     pat_mem [MAX_PATTERN];
  int unsigned              pat_len;
  logic                     pat_closed;
  logic [MAX_PATTERN-1:0]   align_bits;
  logic [POSITION_BITS-1:0] txt_pos;
  logic                     hit_seen;
  logic [POSITION_BITS-1:0] first_hit;
  logic [POSITION_BITS-1:0] latest_hit;

  res_t expected_results [$];

  initial begin
    failures        = 0;
    outstanding     = 0;
    results_checked = 0;
    pattern_words   = 0;
    text_words      = 0;
  end

  task automatic report_mismatch(input string msg);
    if (failures < PRINT_CAP) $display("[%0t] search check: %s", $time, msg);
    failures++;
  endtask

  task automatic clear_search();
    align_bits = '0;
    txt_pos    = '0;
    hit_seen   = 1'b0;
    first_hit  = '0;
    latest_hit = '0;
  endtask

  // Advance the predicted state by one word; push a result on the end of a text
  task automatic predict_search(input logic func, input logic [WORD_W-1:0] word,
                                input logic last);
    logic [MAX_PATTERN-1:0]   eq;
    logic [WORD_BITS-1:0]     w;
    logic [POSITION_BITS-1:0] start;
    int unsigned              k;
    res_t                     r;
    w = WORD_BITS'(word);
    if (func == FUNC_PATTERN) begin
      // a word after a closed pattern opens a new one
      if (pat_closed) begin
        pat_len    = 0;
        pat_closed = 1'b0;
      end
      if (pat_len < MAX_PATTERN) begin
        pat_mem[pat_len] = w;
        pat_len++;
      end
      if (last) pat_closed = 1'b1;
      clear_search();
    end else begin
      pat_closed = 1'b1;
      if (txt_pos != '1) txt_pos++;
      if (pat_len > 0) begin
        eq = '0;
        for (k = 0; k < pat_len; k++) begin
          if (pat_mem[k] == w) eq[k] = 1'b1;
        end
        align_bits = ((align_bits << 1) | MAX_PATTERN'(1)) & eq;
        if (align_bits[pat_len-1]) begin
          start = (txt_pos >= pat_len) ? POSITION_BITS'(txt_pos - pat_len + 1) : '0;
          if (!hit_seen) first_hit = start;
          latest_hit = start;
          hit_seen   = 1'b1;
        end
      end
      if (last) begin
        if (pat_len == 0) begin
          r.found          = 1'b1;
          r.first_position = '0;
          r.last_position  = '0;
        end else begin
          r.found          = hit_seen;
          r.first_position = POS_OUT_W'(first_hit);
          r.last_position  = POS_OUT_W'(latest_hit);
        end
        expected_results.push_back(r);
        clear_search();
      end
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      pat_len    = 0;
      pat_closed = 1'b1;
      clear_search();
      expected_results.delete();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.func == FUNC_PATTERN) pattern_words++;
        else text_words++;
        predict_search(in_ch.func, in_ch.word, in_ch.last);
      end
      if (out_ch.valid && out_ch.ready) begin
        results_checked++;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result with none pending: found %0b first %0d last %0d",
                                    out_ch.found, out_ch.first_position,
                                    out_ch.last_position));
        end else begin
          want = expected_results.pop_front();
          if (out_ch.found !== want.found)
            report_mismatch($sformatf("found %0b, expected %0b", out_ch.found, want.found));
          if (out_ch.first_position !== want.first_position)
            report_mismatch($sformatf("first_position %0d, expected %0d",
                                      out_ch.first_position, want.first_position));
          if (out_ch.last_position !== want.last_position)
            report_mismatch($sformatf("last_position %0d, expected %0d",
                                      out_ch.last_position, want.last_position));
        end
      end
    end
    outstanding <= expected_results.size();
  end

endmodule

/* verif/sequence_pattern_matcher_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequence_pattern_matcher_core_test
// Drives patterns and texts into the pattern matcher: a short directed run
// over the corner cases, then random pattern/text sequences under four
// idling phases. A checker beside the block predicts and compares every
// result.
// ----------------------------------------------------------------------------
module sequence_pattern_matcher_core_test;
  import smp_pkg::*;

  localparam int MAX_PATTERN = 16;
  // The limit allows many times what the slowest honest run of about 1100
  // items needs under the stalls.
  localparam int unsigned CYCLE_LIMIT = 50_000;
  localparam int unsigned DRAIN_TAIL  = 8;
  localparam int unsigned PHASE_ITEMS = 275;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #5 clk = ~clk;

  smp_in_if  in_ch ();
  smp_out_if out_ch ();

  int unsigned failures;
  int unsigned outstanding;
  int unsigned results_checked;
  int unsigned pattern_words;
  int unsigned text_words;

  sequence_pattern_matcher_core #(
    .MAX_PATTERN  (MAX_PATTERN),
    .POSITION_BITS(16),
    .WORD_BITS    (32)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  sequence_pattern_matcher_checker #(
    .MAX_PATTERN  (MAX_PATTERN),
    .POSITION_BITS(16),
    .WORD_BITS    (32)
  ) search_monitor (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .failures       (failures),
    .outstanding    (outstanding),
    .results_checked(results_checked),
    .pattern_words  (pattern_words),
    .text_words     (text_words)
  );

  int unsigned          idle_pct  = 0;
  int unsigned          stall_pct = 0;
  int unsigned          sent_items = 0;
  int unsigned          cycle_count = 0;
  logic [WORD_W-1:0]    pat_words [$];   // current pattern, kept for planting in texts

  // Receiver: stall at random with the phase's probability
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: end the run if the stimulus or the drain hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending",
               cycle_count, outstanding);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Small alphabet with the extremes, so that texts hit the pattern often
  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(19))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return '0;
      3:       return '1;
      4:       return $urandom;
      default: return WORD_W'($urandom_range(1, 3));
    endcase
  endfunction

  // Hold valid until the word is taken; idle beforehand at the phase's rate
  task automatic send_word(input logic func, input logic [WORD_W-1:0] word,
                           input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func  <= func;
    in_ch.word  <= word;
    in_ch.last  <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent_items++;
  endtask

  task automatic send_pattern(input int unsigned len, input bit close);
    logic [WORD_W-1:0] w;
    int unsigned       j;
    pat_words.delete();
    for (j = 0; j < len; j++) begin
      w = pick_word();
      if (pat_words.size() < MAX_PATTERN) pat_words.push_back(w);
      send_word(FUNC_PATTERN, w, close && (j == len - 1));
    end
  endtask

  // Build a text with copies of the pattern planted at random, then stream it
  task automatic send_text(input int unsigned len, input int unsigned plant_pct,
                           input bit close);
    logic [WORD_W-1:0] txt [$];
    int unsigned       j;
    while (txt.size() < len) begin
      if (pat_words.size() != 0 && $urandom_range(99) < plant_pct &&
          txt.size() + pat_words.size() <= len) begin
        for (j = 0; j < pat_words.size(); j++) txt.push_back(pat_words[j]);
      end else begin
        txt.push_back(pick_word());
      end
    end
    for (j = 0; j < txt.size(); j++)
      send_word(FUNC_TEXT, txt[j], close && (j == txt.size() - 1));
  endtask

  function automatic int unsigned pattern_len();
    if ($urandom_range(99) < 15) return $urandom_range(6, MAX_PATTERN);
    return $urandom_range(1, 5);
  endfunction

  task automatic random_sequences(input int unsigned quota);
    int unsigned stop_at;
    int unsigned pick;
    stop_at = sent_items + quota;
    while (sent_items < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        // well-formed: usually a fresh pattern, always a closed text
        if ($urandom_range(4) != 0) send_pattern(pattern_len(), 1'b1);
        send_text($urandom_range(1, 40), 30, 1'b1);
      end else if (pick < 80) begin
        // overflow: words past the capacity are dropped
        send_pattern($urandom_range(MAX_PATTERN + 1, MAX_PATTERN + 6), 1'b1);
        send_text($urandom_range(MAX_PATTERN, 40), 40, 1'b1);
      end else if (pick < 88) begin
        // pattern left open: the first text word closes it
        send_pattern($urandom_range(1, 5), 1'b0);
        send_text($urandom_range(1, 20), 30, 1'b1);
      end else if (pick < 95) begin
        // a new pattern cuts an unfinished text short
        send_text($urandom_range(1, 8), 30, 1'b0);
        send_pattern(pattern_len(), 1'b1);
        send_text($urandom_range(1, 20), 30, 1'b1);
      end else begin
        // raw noise on every field
        repeat ($urandom_range(1, 10))
          send_word(logic'($urandom_range(1)), $urandom, logic'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    int unsigned idle_by_phase  [4];
    int unsigned stall_by_phase [4];
    int unsigned i;
    idle_by_phase  = '{0, 59, 0, 32};
    stall_by_phase = '{0, 0, 59, 32};

    in_ch.valid  <= 1'b0;
    in_ch.func   <= FUNC_TEXT;
    in_ch.word   <= '0;
    in_ch.last   <= 1'b0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Empty pattern right after reset: found with both positions zero
    send_word(FUNC_TEXT, 32'h8000_0000, 1'b1);
    send_word(FUNC_TEXT, '0, 1'b0);
    send_word(FUNC_TEXT, 32'h7fff_ffff, 1'b1);

    // Two-word pattern of the extremes, found twice
    send_word(FUNC_PATTERN, 32'h7fff_ffff, 1'b0);
    send_word(FUNC_PATTERN, 32'h8000_0000, 1'b1);
    send_word(FUNC_TEXT, 32'h7fff_ffff, 1'b0);
    send_word(FUNC_TEXT, 32'h8000_0000, 1'b0);
    send_word(FUNC_TEXT, 32'h7fff_ffff, 1'b0);
    send_word(FUNC_TEXT, 32'h8000_0000, 1'b1);

    // Text shorter than the pattern: nothing found
    send_word(FUNC_TEXT, 32'h7fff_ffff, 1'b1);

    // Pattern left open, closed by text; adjacent occurrences
    send_word(FUNC_PATTERN, '1, 1'b0);
    send_word(FUNC_TEXT, '1, 1'b0);
    send_word(FUNC_TEXT, '1, 1'b1);

    // Same pattern kept for a text with no occurrence
    send_word(FUNC_TEXT, '0, 1'b0);
    send_word(FUNC_TEXT, 32'h0000_0001, 1'b1);

    // Random sequences under each idling phase
    for (i = 0; i < 4; i++) begin
      idle_pct  = idle_by_phase[i];
      stall_pct = stall_by_phase[i];
      random_sequences(PHASE_ITEMS);
    end

    // Drain: drop valid and wait for every pending result
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);

    $display("run covered %0d pattern words and %0d text words, %0d results compared",
             pattern_words, text_words, results_checked);
    $display("idling phases: none, sender 59%%, receiver 59%%, both 32%%; %0d errors",
             failures);
    if (failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/smp_pkg.sv
rtl/smp_in_if.sv
rtl/smp_out_if.sv
rtl/smp_cell.sv
rtl/smp_out_q.sv
rtl/sequence_pattern_matcher_core.sv
verif/sequence_pattern_matcher_checker.sv
verif/sequence_pattern_matcher_core_test.sv
